### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define TGM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tgm check failed");

// check on every clock edge, reset included
`define TGM_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tgm check failed");

`endif

### hdl/tgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgm_pkg;

	localparam int ACC_W      = 16;
	localparam int BTN_W      = 10;
	localparam int STICK_W    = 14;
	localparam int GAIN_W     = 12;
	localparam int DZ_W       = 12;
	localparam int INV_W      = 13;
	localparam int CAL_W      = 15;
	localparam int MODE_W     = 3;
	localparam int FLAG_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int CORD_W     = 34;
	localparam int ANG_W      = 21;
	localparam int TILT_W     = 22;
	localparam int AXIS_W     = 27;
	localparam int SAT_W      = 25;
	localparam int MUL_W      = 27;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DIVD_W     = 50;
	localparam int DIVS_W     = 26;
	localparam int ROOT_W     = 30;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int SQ_W       = 32;
	localparam int ATAN_STEPS = 16;
	localparam int STEP_W     = $clog2(ATAN_STEPS);

	localparam int PI_Q16     = 205887;
	localparam int THRESH_Q12 = 2048;
	localparam int ONE_Q12    = 4096;
	localparam int SAT_Q12    = 16777216;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ANALOG = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DPAD   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ACTION = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TRIG   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TILT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_ANGLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SENS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SENS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ    = 3'd6;

	localparam int OPT_SWAP     = 0;
	localparam int OPT_INV_X    = 1;
	localparam int OPT_INV_Y    = 2;
	localparam int OPT_CIRCULAR = 3;

	localparam logic [BTN_W-1:0] B_RIGHT    = 10'h001;
	localparam logic [BTN_W-1:0] B_DOWN     = 10'h002;
	localparam logic [BTN_W-1:0] B_LEFT     = 10'h004;
	localparam logic [BTN_W-1:0] B_UP       = 10'h008;
	localparam logic [BTN_W-1:0] B_CIRCLE   = 10'h010;
	localparam logic [BTN_W-1:0] B_CROSS    = 10'h020;
	localparam logic [BTN_W-1:0] B_SQUARE   = 10'h040;
	localparam logic [BTN_W-1:0] B_TRIANGLE = 10'h080;
	localparam logic [BTN_W-1:0] B_LTRIG    = 10'h100;
	localparam logic [BTN_W-1:0] B_RTRIG    = 10'h200;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_STEPS] = '{
		21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150,
		21'sd4091,  21'sd2047,  21'sd1024,  21'sd512,
		21'sd256,   21'sd128,   21'sd64,    21'sd32,
		21'sd16,    21'sd8,     21'sd4,     21'sd2
	};

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage
`default_nettype wire

### hdl/tgm_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tgm_sample_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [tgm_pkg::ACC_W-1:0]    accel_x;
	logic signed [tgm_pkg::ACC_W-1:0]    accel_y;
	logic signed [tgm_pkg::ACC_W-1:0]    accel_z;
	logic        [tgm_pkg::BTN_W-1:0]    external_held;

	modport source (output valid, cmd, accel_x, accel_y, accel_z, external_held,
		input ready);
	modport sink (input valid, cmd, accel_x, accel_y, accel_z, external_held,
		output ready);
endinterface
`default_nettype wire

### hdl/tgm_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tgm_result_if;
	logic                                valid;
	logic                                ready;
	logic                                stick_valid;
	logic signed [tgm_pkg::STICK_W-1:0]  stick_x;
	logic signed [tgm_pkg::STICK_W-1:0]  stick_y;
	logic        [tgm_pkg::BTN_W-1:0]    press_mask;
	logic        [tgm_pkg::BTN_W-1:0]    release_mask;

	modport source (output valid, stick_valid, stick_x, stick_y, press_mask,
		release_mask, input ready);
	modport sink (input valid, stick_valid, stick_x, stick_y, press_mask,
		release_mask, output ready);
endinterface
`default_nettype wire

### hdl/tilt_to_gamepad_mapper_unit.sv
// Channel    Dir  Handshake      Payload
// sample_ch  in   valid/ready    cmd, accel_x, accel_y, accel_z, external_held
// result_ch  out  valid/ready    stick_valid, stick_x, stick_y, press_mask, release_mask
// cfg        in   cfg_we         cfg_index, cfg_data
//
// One item at a time. A release command or off mode goes straight to the result; a button
// mode runs a 30-step square root, two 16-step CORDIC passes and gain multiplies.
// Analog mode adds up to two 50-step divisions for the deadzone; the circular
// inverse deadzone adds another square root and two more divisions.
// Reset clears state and held buttons and sets the config registers to their defaults at once.
// A finished item waits in the output register while the next one is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tilt_to_gamepad_mapper_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	tgm_sample_if.sink                          sample_ch,
	tgm_result_if.source                        result_ch,
	input  logic                                cfg_we,
	input  logic [tgm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tgm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int AW = tgm_pkg::AXIS_W;
	localparam int G3W = tgm_pkg::GAIN_W + 2;
	localparam logic signed [tgm_pkg::ANG_W-1:0] PiA = tgm_pkg::ANG_W'(tgm_pkg::PI_Q16);
	localparam logic signed [tgm_pkg::TILT_W-1:0] ThrT =
		tgm_pkg::TILT_W'(tgm_pkg::THRESH_Q12);
	localparam logic signed [AW-1:0] OneA = AW'(tgm_pkg::ONE_Q12);
	localparam logic signed [AW-1:0] SatA = AW'(tgm_pkg::SAT_Q12);
	localparam logic [tgm_pkg::DIVD_W:0] SatQ = (tgm_pkg::DIVD_W + 1)'(tgm_pkg::SAT_Q12);
	localparam logic [tgm_pkg::STEP_W-1:0] StepLast = tgm_pkg::STEP_W'(tgm_pkg::ATAN_STEPS - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MSQ1, ST_MSQ2, ST_MSQ3, ST_HYPW, ST_CORD, ST_TX, ST_TY, ST_TYW,
		ST_DZS, ST_DZW, ST_INV, ST_CM1, ST_CM2, ST_CM3, ST_CMW, ST_CS, ST_CSD, ST_CSW,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [tgm_pkg::MODE_W-1:0]          mode_q;
	logic [tgm_pkg::FLAG_W-1:0]          flags_q;
	logic signed [tgm_pkg::CAL_W-1:0]    cal_q;
	logic [tgm_pkg::GAIN_W-1:0]          xs_q, ys_q;
	logic [tgm_pkg::DZ_W-1:0]            dz_q;
	logic [tgm_pkg::INV_W-1:0]           inv_q;
	logic [tgm_pkg::BTN_W-1:0]           held_q;

	logic                                cmd_q;
	logic signed [tgm_pkg::ACC_W-1:0]    ax_q, ay_q, az_q;
	logic [tgm_pkg::BTN_W-1:0]           ext_q;
	logic [tgm_pkg::DIVD_W-1:0]          acc_q;
	logic signed [tgm_pkg::PROD_W-1:0]   prod_q;
	logic signed [tgm_pkg::CORD_W-1:0]   cx_q, cy_q;
	logic signed [tgm_pkg::ANG_W-1:0]    cz_q;
	logic [tgm_pkg::STEP_W-1:0]          it_q;
	logic                                csel_q;
	logic signed [tgm_pkg::ANG_W-1:0]    xa_q, ya_q;
	logic signed [tgm_pkg::TILT_W-1:0]   tx_q, ty_q;
	logic                                axis_q;
	logic                                neg_q;
	logic signed [AW-1:0]                vx_q, vy_q;
	logic [tgm_pkg::DIVS_W-1:0]          m_q;

	logic                                out_valid_q;
	logic                                o_stick_valid_q;
	logic signed [tgm_pkg::STICK_W-1:0]  o_sx_q, o_sy_q;
	logic [tgm_pkg::BTN_W-1:0]           o_press_q, o_rel_q;

	tgm_pkg::div_req_t  div_req;
	tgm_pkg::div_rsp_t  div_rsp;
	tgm_pkg::sqrt_req_t sqrt_req;
	tgm_pkg::sqrt_rsp_t sqrt_rsp;

	tgm_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	tgm_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	logic                                accept;
	logic signed [tgm_pkg::ACC_W-1:0]    sw_x, sw_y;
	logic [G3W-1:0]                      xs3, ys3;
	logic signed [tgm_pkg::MUL_W-1:0]    mul_a, mul_b;
	logic [tgm_pkg::DIVD_W-1:0]          sq_sum;
	logic signed [tgm_pkg::PROD_W-1:0]   rnd;
	logic signed [tgm_pkg::TILT_W-1:0]   tilt_new;
	logic signed [AW-1:0]                v_sel, v_abs, inv_a;
	logic [tgm_pkg::DIVS_W-1:0]          m_inv;

	logic signed [tgm_pkg::CORD_W-1:0]   sx_c, sy_c, nx_c, ny_c;
	logic signed [tgm_pkg::ANG_W-1:0]    nz_c, z_fin, xa_new, ya_raw, ya_new, cal16;
	logic                                cord_done;
	logic signed [tgm_pkg::CORD_W-1:0]   yx0, yy0, yxi, yyi;
	logic signed [tgm_pkg::ANG_W-1:0]    yzi;

	logic signed [tgm_pkg::TILT_W+1:0]   t_e, d_e, num_p, num_n;
	logic                                dz_pos, dz_neg;
	logic [tgm_pkg::DIVD_W:0]            qd;
	logic signed [AW-1:0]                sat_v, dz_res, cs_res;

	logic                                f_valid;
	logic signed [tgm_pkg::STICK_W-1:0]  f_sx, f_sy;
	logic [tgm_pkg::BTN_W-1:0]           f_press, f_rel, f_held;
	logic                                fin_go;

	function automatic logic signed [tgm_pkg::STICK_W-1:0] clamp_one(
		input logic signed [AW-1:0] v);
		logic signed [tgm_pkg::STICK_W-1:0] r;
		if (v > OneA)
			r = OneA[tgm_pkg::STICK_W-1:0];
		else if (v < -OneA)
			r = -OneA[tgm_pkg::STICK_W-1:0];
		else
			r = v[tgm_pkg::STICK_W-1:0];
		return r;
	endfunction

	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);

	assign sw_x = flags_q[tgm_pkg::OPT_SWAP] ? sample_ch.accel_y : sample_ch.accel_x;
	assign sw_y = flags_q[tgm_pkg::OPT_SWAP] ? sample_ch.accel_x : sample_ch.accel_y;

	assign xs3 = {2'b00, xs_q} + {1'b0, xs_q, 1'b0};
	assign ys3 = {2'b00, ys_q} + {1'b0, ys_q, 1'b0};

	assign v_sel = axis_q ? vy_q : vx_q;
	assign v_abs = v_sel[AW-1] ? -v_sel : v_sel;
	assign inv_a = AW'(inv_q);
	assign m_inv = m_q + tgm_pkg::DIVS_W'(inv_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MSQ1: begin
				mul_a = tgm_pkg::MUL_W'(ay_q);
				mul_b = tgm_pkg::MUL_W'(ay_q);
			end
			ST_MSQ2: begin
				mul_a = tgm_pkg::MUL_W'(az_q);
				mul_b = tgm_pkg::MUL_W'(az_q);
			end
			ST_TX: begin
				mul_a = tgm_pkg::MUL_W'(xa_q);
				mul_b = {{(tgm_pkg::MUL_W - G3W){1'b0}}, xs3};
			end
			ST_TY: begin
				mul_a = tgm_pkg::MUL_W'(ya_q);
				mul_b = {{(tgm_pkg::MUL_W - G3W){1'b0}}, ys3};
			end
			ST_CM1: begin
				mul_a = vx_q;
				mul_b = vx_q;
			end
			ST_CM2: begin
				mul_a = vy_q;
				mul_b = vy_q;
			end
			ST_CS: begin
				mul_a = v_abs;
				mul_b = {1'b0, m_inv};
			end
			default: begin
			end
		endcase
	end

	assign sq_sum   = acc_q + prod_q[tgm_pkg::DIVD_W-1:0];
	assign rnd      = prod_q + {{(tgm_pkg::PROD_W - 12){1'b0}}, 12'd2048};
	assign tilt_new = rnd[tgm_pkg::TILT_W+11:12];

	// CORDIC vectoring step
	assign sx_c  = cx_q >>> it_q;
	assign sy_c  = cy_q >>> it_q;
	assign nx_c  = cy_q[tgm_pkg::CORD_W-1] ? cx_q - sy_c : cx_q + sy_c;
	assign ny_c  = cy_q[tgm_pkg::CORD_W-1] ? cy_q + sx_c : cy_q - sx_c;
	assign nz_c  = cy_q[tgm_pkg::CORD_W-1] ? cz_q - tgm_pkg::ATAN_TAB[it_q]
		: cz_q + tgm_pkg::ATAN_TAB[it_q];
	assign cord_done = (cy_q == '0) || (it_q == StepLast);
	assign z_fin  = (cy_q == '0) ? cz_q : nz_c;
	assign xa_new = flags_q[tgm_pkg::OPT_INV_X] ? -z_fin : z_fin;
	assign cal16  = {{2{cal_q[tgm_pkg::CAL_W-1]}}, cal_q, 4'b0000};
	assign ya_raw = z_fin - cal16;
	assign ya_new = flags_q[tgm_pkg::OPT_INV_Y] ? -ya_raw : ya_raw;

	assign yx0 = {{4{ay_q[tgm_pkg::ACC_W-1]}}, ay_q, 14'd0};
	assign yy0 = {{4{az_q[tgm_pkg::ACC_W-1]}}, az_q, 14'd0};
	assign yxi = yx0[tgm_pkg::CORD_W-1] ? -yx0 : yx0;
	assign yyi = yx0[tgm_pkg::CORD_W-1] ? -yy0 : yy0;
	assign yzi = yx0[tgm_pkg::CORD_W-1] ? (yy0[tgm_pkg::CORD_W-1] ? -PiA : PiA) : '0;

	// deadzone
	assign t_e    = (tgm_pkg::TILT_W + 2)'(axis_q ? ty_q : tx_q);
	assign d_e    = (tgm_pkg::TILT_W + 2)'(dz_q);
	assign dz_pos = (t_e > d_e);
	assign dz_neg = (t_e < -d_e);
	assign num_p  = t_e - d_e;
	assign num_n  = -t_e - d_e;
	assign qd     = {1'b0, div_rsp.quot} + (tgm_pkg::DIVD_W + 1)'(dz_q);
	assign sat_v  = (qd > SatQ) ? SatA : {2'b00, qd[tgm_pkg::SAT_W-1:0]};
	assign dz_res = neg_q ? -sat_v : sat_v;
	assign cs_res = v_sel[AW-1] ? -{1'b0, div_rsp.quot[AW-2:0]}
		: {1'b0, div_rsp.quot[AW-2:0]};

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {{(tgm_pkg::DIVD_W - tgm_pkg::TILT_W - 12){1'b0}},
			(dz_pos ? num_p[tgm_pkg::TILT_W-1:0] : num_n[tgm_pkg::TILT_W-1:0]), 12'd0};
		div_req.divisor  = tgm_pkg::DIVS_W'(13'd4096 - {1'b0, dz_q});
		if (state_q == ST_DZS) begin
			div_req.start = dz_pos || dz_neg;
		end else if (state_q == ST_CSD) begin
			div_req.start    = 1'b1;
			div_req.dividend = prod_q[tgm_pkg::DIVD_W-1:0];
			div_req.divisor  = m_q;
		end
	end

	always_comb begin
		sqrt_req.start    = (state_q == ST_MSQ3) || (state_q == ST_CM3);
		sqrt_req.radicand = (state_q == ST_MSQ3)
			? {sq_sum[tgm_pkg::SQ_W-1:0], {(tgm_pkg::RAD_W - tgm_pkg::SQ_W){1'b0}}}
			: {{(tgm_pkg::RAD_W - tgm_pkg::DIVD_W){1'b0}}, sq_sum};
	end

	// result and held buttons
	always_comb begin
		logic xn, xp, yn, yp, dp;
		logic [tgm_pkg::BTN_W-1:0] blocked, xm, ym, pr, up, dn;
		xn = (tx_q < -ThrT);
		xp = (tx_q > ThrT);
		yn = (ty_q < -ThrT);
		yp = (ty_q > ThrT);
		dp = (mode_q == tgm_pkg::MODE_DPAD);
		blocked = ext_q | held_q;
		xm = dp ? (tgm_pkg::B_RIGHT | tgm_pkg::B_LEFT) : (tgm_pkg::B_SQUARE | tgm_pkg::B_CIRCLE);
		ym = dp ? (tgm_pkg::B_UP | tgm_pkg::B_DOWN) : (tgm_pkg::B_TRIANGLE | tgm_pkg::B_CROSS);
		pr = '0;
		up = '0;
		dn = '0;
		f_valid = 1'b0;
		f_sx    = '0;
		f_sy    = '0;
		f_press = '0;
		f_rel   = '0;
		f_held  = held_q;
		if (cmd_q) begin
			f_valid = 1'b1;
			f_rel   = held_q;
			f_held  = '0;
		end else begin
			unique case (mode_q)
				tgm_pkg::MODE_ANALOG: begin
					f_valid = 1'b1;
					f_sx    = clamp_one(vx_q);
					f_sy    = clamp_one(vy_q);
				end
				tgm_pkg::MODE_DPAD, tgm_pkg::MODE_ACTION: begin
					if (!xn && !xp) begin
						f_rel  = f_rel | (held_q & xm);
						f_held = f_held & ~xm;
					end
					if (!yn && !yp) begin
						f_rel  = f_rel | (held_q & ym);
						f_held = f_held & ~ym;
					end
					if (xn || xp || yn || yp) begin
						if (xn) pr = pr | (dp ? tgm_pkg::B_LEFT : tgm_pkg::B_SQUARE);
						if (xp) pr = pr | (dp ? tgm_pkg::B_RIGHT : tgm_pkg::B_CIRCLE);
						if (yn) pr = pr | (dp ? tgm_pkg::B_DOWN : tgm_pkg::B_CROSS);
						if (yp) pr = pr | (dp ? tgm_pkg::B_UP : tgm_pkg::B_TRIANGLE);
						f_press = pr & ~blocked;
						f_held  = f_held | f_press;
					end
				end
				tgm_pkg::MODE_TRIG: begin
					priority if (yp) begin
						dn = tgm_pkg::B_LTRIG | tgm_pkg::B_RTRIG;
					end else if (!xn && !xp) begin
						up = tgm_pkg::B_LTRIG | tgm_pkg::B_RTRIG;
					end else if (xn) begin
						dn = tgm_pkg::B_LTRIG;
						up = tgm_pkg::B_RTRIG;
					end else begin
						dn = tgm_pkg::B_RTRIG;
						up = tgm_pkg::B_LTRIG;
					end
					f_press = dn & ~blocked;
					f_rel   = held_q & up;
					f_held  = (held_q & ~up) | f_press;
				end
				default: begin
				end
			endcase
		end
	end

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= tgm_pkg::MODE_OFF;
			flags_q     <= '0;
			cal_q       <= '0;
			xs_q        <= 12'd256;
			ys_q        <= 12'd256;
			dz_q        <= '0;
			inv_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (cfg_we) begin
				unique case (cfg_index)
					tgm_pkg::CFG_TILT_MODE: mode_q  <= cfg_data[tgm_pkg::MODE_W-1:0];
					tgm_pkg::CFG_OPTIONS:   flags_q <= cfg_data[tgm_pkg::FLAG_W-1:0];
					tgm_pkg::CFG_CAL_ANGLE: cal_q   <= cfg_data[tgm_pkg::CAL_W-1:0];
					tgm_pkg::CFG_X_SENS:    xs_q    <= cfg_data[tgm_pkg::GAIN_W-1:0];
					tgm_pkg::CFG_Y_SENS:    ys_q    <= cfg_data[tgm_pkg::GAIN_W-1:0];
					tgm_pkg::CFG_DEADZONE:  dz_q    <= cfg_data[tgm_pkg::DZ_W-1:0];
					tgm_pkg::CFG_INV_DZ:    inv_q   <= cfg_data[tgm_pkg::INV_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && result_ch.ready && !fin_go)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= sample_ch.cmd;
						ax_q  <= sw_x;
						ay_q  <= sw_y;
						az_q  <= sample_ch.accel_z;
						ext_q <= sample_ch.external_held;
						if (sample_ch.cmd || mode_q == tgm_pkg::MODE_OFF
							|| mode_q > tgm_pkg::MODE_TRIG)
							state_q <= ST_FIN;
						else
							state_q <= ST_MSQ1;
					end
				end
				ST_MSQ1: state_q <= ST_MSQ2;
				ST_MSQ2: begin
					acc_q   <= prod_q[tgm_pkg::DIVD_W-1:0];
					state_q <= ST_MSQ3;
				end
				ST_MSQ3: state_q <= ST_HYPW;
				ST_HYPW: begin
					if (sqrt_rsp.done) begin
						cx_q    <= tgm_pkg::CORD_W'(sqrt_rsp.root);
						cy_q    <= {{4{ax_q[tgm_pkg::ACC_W-1]}}, ax_q, 14'd0};
						cz_q    <= '0;
						it_q    <= '0;
						csel_q  <= 1'b0;
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						if (!csel_q) begin
							xa_q   <= xa_new;
							cx_q   <= yxi;
							cy_q   <= yyi;
							cz_q   <= yzi;
							it_q   <= '0;
							csel_q <= 1'b1;
						end else begin
							ya_q    <= ya_new;
							state_q <= ST_TX;
						end
					end else begin
						cx_q <= nx_c;
						cy_q <= ny_c;
						cz_q <= nz_c;
						it_q <= it_q + 1'b1;
					end
				end
				ST_TX: state_q <= ST_TY;
				ST_TY: begin
					tx_q    <= tilt_new;
					state_q <= ST_TYW;
				end
				ST_TYW: begin
					ty_q   <= tilt_new;
					axis_q <= 1'b0;
					state_q <= (mode_q == tgm_pkg::MODE_ANALOG) ? ST_DZS : ST_FIN;
				end
				ST_DZS: begin
					neg_q <= !dz_pos;
					if (dz_pos || dz_neg) begin
						state_q <= ST_DZW;
					end else begin
						if (axis_q) vy_q <= '0;
						else vx_q <= '0;
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_INV : ST_DZS;
					end
				end
				ST_DZW: begin
					if (div_rsp.done) begin
						if (axis_q) vy_q <= dz_res;
						else vx_q <= dz_res;
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_INV : ST_DZS;
					end
				end
				ST_INV: begin
					priority if (inv_q == '0) begin
						state_q <= ST_FIN;
					end else if (flags_q[tgm_pkg::OPT_CIRCULAR]) begin
						state_q <= ST_CM1;
					end else begin
						vx_q    <= vx_q + (vx_q[AW-1] ? -inv_a : inv_a);
						vy_q    <= vy_q + (vy_q[AW-1] ? -inv_a : inv_a);
						state_q <= ST_FIN;
					end
				end
				ST_CM1: state_q <= ST_CM2;
				ST_CM2: begin
					acc_q   <= prod_q[tgm_pkg::DIVD_W-1:0];
					state_q <= ST_CM3;
				end
				ST_CM3: state_q <= ST_CMW;
				ST_CMW: begin
					if (sqrt_rsp.done) begin
						m_q    <= sqrt_rsp.root[tgm_pkg::DIVS_W-1:0];
						axis_q <= 1'b0;
						if (sqrt_rsp.root == '0) begin
							vx_q    <= '0;
							vy_q    <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_CS;
						end
					end
				end
				ST_CS:  state_q <= ST_CSD;
				ST_CSD: state_q <= ST_CSW;
				ST_CSW: begin
					if (div_rsp.done) begin
						if (axis_q) vy_q <= cs_res;
						else vx_q <= cs_res;
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_FIN : ST_CS;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q     <= 1'b1;
						o_stick_valid_q <= f_valid;
						o_sx_q          <= f_sx;
						o_sy_q          <= f_sy;
						o_press_q       <= f_press;
						o_rel_q         <= f_rel;
						held_q          <= f_held;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.stick_valid  = o_stick_valid_q;
	assign result_ch.stick_x      = o_sx_q;
	assign result_ch.stick_y      = o_sy_q;
	assign result_ch.press_mask   = o_press_q;
	assign result_ch.release_mask = o_rel_q;

	`TGM_ASSERT(a_masks_disjoint, result_ch.valid |-> ((result_ch.press_mask & result_ch.release_mask) == '0))
	`TGM_ASSERT(a_stick_no_press, result_ch.valid && result_ch.stick_valid |-> result_ch.press_mask == '0)
	`TGM_ASSERT(a_accept_busy, sample_ch.valid && sample_ch.ready |=> state_q != ST_IDLE)
	`TGM_ASSERT(a_div_done_wait, div_rsp.done |-> state_q == ST_DZW || state_q == ST_CSW)
	`TGM_ASSERT(a_sqrt_done_wait, sqrt_rsp.done |-> state_q == ST_HYPW || state_q == ST_CMW)
	`TGM_ASSERT_ALWAYS(a_reset_no_out, !arst_n |-> !result_ch.valid)
endmodule
`default_nettype wire

### hdl/tgm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tgm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tgm_pkg::div_req_t   req,
	output tgm_pkg::div_rsp_t   rsp
);
	localparam int CntW = $clog2(tgm_pkg::DIVD_W);
	localparam logic [CntW-1:0] Last = CntW'(tgm_pkg::DIVD_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CntW-1:0]             cnt_q;
	logic [tgm_pkg::DIVD_W-1:0]  dq_q;
	logic [tgm_pkg::DIVS_W-1:0]  rem_q;
	logic [tgm_pkg::DIVS_W-1:0]  den_q;
	logic [tgm_pkg::DIVS_W:0]    sh;
	logic [tgm_pkg::DIVS_W:0]    diff;
	logic                        ge;

	assign sh   = {rem_q, dq_q[tgm_pkg::DIVD_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dq_q   <= req.dividend;
				den_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[tgm_pkg::DIVS_W-1:0] : sh[tgm_pkg::DIVS_W-1:0];
				dq_q  <= {dq_q[tgm_pkg::DIVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == Last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;
endmodule
`default_nettype wire

### hdl/tgm_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module tgm_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  tgm_pkg::sqrt_req_t  req,
	output tgm_pkg::sqrt_rsp_t  rsp
);
	localparam int CntW = $clog2(tgm_pkg::ROOT_W);
	localparam logic [CntW-1:0] Last = CntW'(tgm_pkg::ROOT_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CntW-1:0]             cnt_q;
	logic [tgm_pkg::RAD_W-1:0]   rad_q;
	logic [tgm_pkg::ROOT_W:0]    rem_q;
	logic [tgm_pkg::ROOT_W-1:0]  root_q;
	logic [tgm_pkg::ROOT_W+2:0]  r2;
	logic [tgm_pkg::ROOT_W+2:0]  trial;
	logic [tgm_pkg::ROOT_W+2:0]  diff;
	logic                        ge;

	assign r2    = {rem_q, rad_q[tgm_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = r2 - trial;
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= req.radicand;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[tgm_pkg::ROOT_W:0] : r2[tgm_pkg::ROOT_W:0];
				root_q <= {root_q[tgm_pkg::ROOT_W-2:0], ge};
				rad_q  <= {rad_q[tgm_pkg::RAD_W-3:0], 2'b00};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == Last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam bit CMD_SAMPLE  = 1'b0;
	localparam bit CMD_RELEASE = 1'b1;

	typedef struct {
		logic                              stick_valid;
		logic signed [tgm_pkg::STICK_W-1:0] stick_x;
		logic signed [tgm_pkg::STICK_W-1:0] stick_y;
		logic [tgm_pkg::BTN_W-1:0]          press_mask;
		logic [tgm_pkg::BTN_W-1:0]          release_mask;
	} gamepad_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tgm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tgm_pkg::CFG_DATA_W-1:0] cfg_data;

	tgm_sample_if sample_ch ();
	tgm_result_if result_ch ();

	tilt_to_gamepad_mapper_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [tgm_pkg::MODE_W-1:0] mode_q;
	logic [tgm_pkg::FLAG_W-1:0] flags_q;
	longint cal_q, xsens_q, ysens_q, dz_q, invdz_q;
	logic [tgm_pkg::BTN_W-1:0] tilt_held;

	gamepad_out_t pending_outputs[$];
	int errors = 0;
	bit idle_on = 1'b1;
	int rx_stall_left = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50ms;
		$display("FAIL tilt_to_gamepad_mapper_unit");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint cordic_atan2(longint yv, longint xv);
		longint z, nx, ny;
		z = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			z = (yv >= 0) ? tgm_pkg::PI_Q16 : -tgm_pkg::PI_Q16;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < tgm_pkg::ATAN_STEPS; i++) begin
			if (yv == 0)
				break;
			if (yv > 0) begin
				nx = xv + (yv >>> i);
				ny = yv - (xv >>> i);
				z += longint'(tgm_pkg::ATAN_TAB[i]);
			end else begin
				nx = xv - (yv >>> i);
				ny = yv + (xv >>> i);
				z -= longint'(tgm_pkg::ATAN_TAB[i]);
			end
			xv = nx;
			yv = ny;
		end
		return z;
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint apply_deadzone(longint v, longint d);
		longint r;
		if (v > d)
			r = (v - d) * tgm_pkg::ONE_Q12 / (tgm_pkg::ONE_Q12 - d) + d;
		else if (v < -d)
			r = -((-v - d) * tgm_pkg::ONE_Q12 / (tgm_pkg::ONE_Q12 - d)) - d;
		else
			r = 0;
		return clamp_sym(r, tgm_pkg::SAT_Q12);
	endfunction

	function automatic longint radial_scale(longint v, longint m, longint inv);
		longint a, q;
		a = (v < 0) ? -v : v;
		q = a * (m + inv) / m;
		return (v < 0) ? -q : q;
	endfunction

	function automatic gamepad_out_t map_tilt(bit cmd, longint ax, longint ay, longint az,
		logic [tgm_pkg::BTN_W-1:0] ext);
		gamepad_out_t o;
		longint t, hyp, xa, ya, tx, ty, x, y, m;
		logic [tgm_pkg::BTN_W-1:0] blocked, xm, ym, up, dn;
		int dx, dy;
		bit dp;
		o = '{1'b0, '0, '0, '0, '0};
		if (cmd == CMD_RELEASE) begin
			o.release_mask = tilt_held;
			tilt_held = '0;
			o.stick_valid = 1'b1;
		end else if (mode_q >= tgm_pkg::MODE_ANALOG && mode_q <= tgm_pkg::MODE_TRIG) begin
			if (flags_q[tgm_pkg::OPT_SWAP]) begin
				t = ax;
				ax = ay;
				ay = t;
			end
			hyp = longint'(int_sqrt(longint'(ay * ay + az * az) << 28));
			xa = cordic_atan2(ax * 16384, hyp);
			ya = cordic_atan2(az * 16384, ay * 16384) - cal_q * 16;
			if (flags_q[tgm_pkg::OPT_INV_X])
				xa = -xa;
			if (flags_q[tgm_pkg::OPT_INV_Y])
				ya = -ya;
			tx = (xa * xsens_q * 3 + 2048) >>> 12;
			ty = (ya * ysens_q * 3 + 2048) >>> 12;
			if (mode_q == tgm_pkg::MODE_ANALOG) begin
				x = apply_deadzone(tx, dz_q);
				y = apply_deadzone(ty, dz_q);
				if (invdz_q == 0) begin
				end else if (flags_q[tgm_pkg::OPT_CIRCULAR]) begin
					m = longint'(int_sqrt(x * x + y * y));
					if (m == 0) begin
						x = 0;
						y = 0;
					end else begin
						x = radial_scale(x, m, invdz_q);
						y = radial_scale(y, m, invdz_q);
					end
				end else begin
					x += (x >= 0) ? invdz_q : -invdz_q;
					y += (y >= 0) ? invdz_q : -invdz_q;
				end
				o.stick_x = tgm_pkg::STICK_W'(clamp_sym(x, tgm_pkg::ONE_Q12));
				o.stick_y = tgm_pkg::STICK_W'(clamp_sym(y, tgm_pkg::ONE_Q12));
				o.stick_valid = 1'b1;
			end else begin
				dx = (tx < -tgm_pkg::THRESH_Q12) ? -1 : (tx > tgm_pkg::THRESH_Q12) ? 1 : 0;
				dy = (ty < -tgm_pkg::THRESH_Q12) ? -1 : (ty > tgm_pkg::THRESH_Q12) ? 1 : 0;
				blocked = ext | tilt_held;
				if (mode_q != tgm_pkg::MODE_TRIG) begin
					dp = (mode_q == tgm_pkg::MODE_DPAD);
					xm = dp ? (tgm_pkg::B_RIGHT | tgm_pkg::B_LEFT)
						: (tgm_pkg::B_SQUARE | tgm_pkg::B_CIRCLE);
					ym = dp ? (tgm_pkg::B_UP | tgm_pkg::B_DOWN)
						: (tgm_pkg::B_TRIANGLE | tgm_pkg::B_CROSS);
					if (dx == 0) begin
						o.release_mask |= tilt_held & xm;
						tilt_held &= ~xm;
					end
					if (dy == 0) begin
						o.release_mask |= tilt_held & ym;
						tilt_held &= ~ym;
					end
					if (dx != 0 || dy != 0) begin
						if (dx == -1) o.press_mask |= dp ? tgm_pkg::B_LEFT : tgm_pkg::B_SQUARE;
						if (dx == 1) o.press_mask |= dp ? tgm_pkg::B_RIGHT : tgm_pkg::B_CIRCLE;
						if (dy == -1) o.press_mask |= dp ? tgm_pkg::B_DOWN : tgm_pkg::B_CROSS;
						if (dy == 1) o.press_mask |= dp ? tgm_pkg::B_UP : tgm_pkg::B_TRIANGLE;
						o.press_mask &= ~blocked;
						tilt_held |= o.press_mask;
					end
				end else begin
					up = '0;
					dn = '0;
					if (dy == 1) begin
						dn = tgm_pkg::B_LTRIG | tgm_pkg::B_RTRIG;
					end else if (dx == 0) begin
						up = tgm_pkg::B_LTRIG | tgm_pkg::B_RTRIG;
					end else if (dx == -1) begin
						dn = tgm_pkg::B_LTRIG;
						up = tgm_pkg::B_RTRIG;
					end else begin
						dn = tgm_pkg::B_RTRIG;
						up = tgm_pkg::B_LTRIG;
					end
					dn &= ~blocked;
					o.press_mask = dn;
					o.release_mask = tilt_held & up;
					tilt_held = (tilt_held & ~up) | dn;
				end
			end
		end
		return o;
	endfunction

	// receiver: random stalls plus a forced hold-off
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall_left > 0) begin
				result_ch.ready = 1'b0;
				rx_stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				result_ch.ready = 1'b0;
				rx_stall_left = $urandom_range(1, 17) - 1;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		gamepad_out_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				e = pending_outputs.pop_front();
				if (result_ch.stick_valid !== e.stick_valid) begin
					$error("stick_valid exp %0d got %0d", e.stick_valid, result_ch.stick_valid);
					errors++;
				end
				if (result_ch.stick_x !== e.stick_x) begin
					$error("stick_x exp %0d got %0d", e.stick_x, result_ch.stick_x);
					errors++;
				end
				if (result_ch.stick_y !== e.stick_y) begin
					$error("stick_y exp %0d got %0d", e.stick_y, result_ch.stick_y);
					errors++;
				end
				if (result_ch.press_mask !== e.press_mask) begin
					$error("press_mask exp %h got %h", e.press_mask, result_ch.press_mask);
					errors++;
				end
				if (result_ch.release_mask !== e.release_mask) begin
					$error("release_mask exp %h got %h", e.release_mask,
						result_ch.release_mask);
					errors++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(bit cmd, logic signed [tgm_pkg::ACC_W-1:0] ax,
		logic signed [tgm_pkg::ACC_W-1:0] ay, logic signed [tgm_pkg::ACC_W-1:0] az,
		logic [tgm_pkg::BTN_W-1:0] ext);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			sample_ch.valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.cmd = cmd;
		sample_ch.accel_x = ax;
		sample_ch.accel_y = ay;
		sample_ch.accel_z = az;
		sample_ch.external_held = ext;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pending_outputs.push_back(map_tilt(cmd, ax, ay, az, ext));
		@(negedge clk);
	endtask

	task automatic drain_outputs();
		sample_ch.valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [tgm_pkg::CFG_IDX_W-1:0] idx, longint val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = tgm_pkg::CFG_DATA_W'(val);
		case (idx)
			tgm_pkg::CFG_TILT_MODE: mode_q = tgm_pkg::MODE_W'(val);
			tgm_pkg::CFG_OPTIONS:   flags_q = tgm_pkg::FLAG_W'(val);
			tgm_pkg::CFG_CAL_ANGLE: cal_q = val;
			tgm_pkg::CFG_X_SENS:    xsens_q = val;
			tgm_pkg::CFG_Y_SENS:    ysens_q = val;
			tgm_pkg::CFG_DEADZONE:  dz_q = val;
			tgm_pkg::CFG_INV_DZ:    invdz_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_all(logic [tgm_pkg::MODE_W-1:0] md, logic [tgm_pkg::FLAG_W-1:0] fl,
		longint cal, longint xs, longint ys, longint dz, longint inv);
		write_reg(tgm_pkg::CFG_TILT_MODE, longint'(md));
		write_reg(tgm_pkg::CFG_OPTIONS, longint'(fl));
		write_reg(tgm_pkg::CFG_CAL_ANGLE, cal);
		write_reg(tgm_pkg::CFG_X_SENS, xs);
		write_reg(tgm_pkg::CFG_Y_SENS, ys);
		write_reg(tgm_pkg::CFG_DEADZONE, dz);
		write_reg(tgm_pkg::CFG_INV_DZ, inv);
	endtask

	function automatic logic signed [tgm_pkg::ACC_W-1:0] rand_accel();
		case ($urandom_range(0, 3))
			0: return tgm_pkg::ACC_W'($urandom);
			1: return tgm_pkg::ACC_W'($signed($urandom_range(0, 400)) - 200);
			2: return tgm_pkg::ACC_W'($signed($urandom_range(0, 8000)) - 4000);
			default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_sample(($urandom_range(0, 15) == 0) ? CMD_RELEASE : CMD_SAMPLE,
				rand_accel(), rand_accel(), rand_accel(),
				($urandom_range(0, 2) == 0) ? tgm_pkg::BTN_W'($urandom) : '0);
	endtask

	task automatic test_directed();
		for (int md = tgm_pkg::MODE_ANALOG; md <= tgm_pkg::MODE_TRIG; md++) begin
			set_all(tgm_pkg::MODE_W'(md), 4'd0, 0, 256, 256, 0, 0);
			send_sample(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0, '0);
			send_sample(CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0);
			send_sample(CMD_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 10'h3ff);
			send_sample(CMD_SAMPLE, -16'sd16000, 16'sd100, -16'sd16000, '0);
			send_sample(CMD_SAMPLE, 16'sd16000, -16'sd16000, 16'sd0, '0);
			send_sample(CMD_RELEASE, 16'sd0, 16'sd0, 16'sd0, '0);
			drain_outputs();
		end
		set_all(tgm_pkg::MODE_OFF, 4'hf, 0, 256, 256, 0, 0);
		send_sample(CMD_SAMPLE, 16'sd1000, 16'sd1000, 16'sd1000, '0);
		send_sample(CMD_RELEASE, 16'sd0, 16'sd0, 16'sd0, '0);
		drain_outputs();
	endtask

	task automatic test_extremes();
		set_all(tgm_pkg::MODE_ANALOG, 4'hf, 12868, 2560, 2560, 4064, 4096);
		send_random(60);
		drain_outputs();
		set_all(tgm_pkg::MODE_ANALOG, 4'h6, -12868, 0, 2560, 4064, 1);
		send_random(60);
		drain_outputs();
		set_all(tgm_pkg::MODE_DPAD, 4'h9, -12868, 2560, 0, 0, 4096);
		send_random(60);
		drain_outputs();
	endtask

	task automatic test_random_configs(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_all(tgm_pkg::MODE_W'($urandom_range(0, 7)), tgm_pkg::FLAG_W'($urandom),
				$signed($urandom_range(0, 25736)) - 12868,
				$urandom_range(0, 2560), $urandom_range(0, 2560),
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4064),
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4096));
			send_random(per_phase);
			drain_outputs();
		end
	endtask

	task automatic test_output_hold_off();
		set_all(tgm_pkg::MODE_TRIG, 4'd0, 0, 1024, 1024, 0, 0);
		rx_stall_left = 1500;
		send_random(12);
		drain_outputs();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.cmd = CMD_SAMPLE;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		sample_ch.external_held = '0;
		mode_q = tgm_pkg::MODE_OFF;
		flags_q = '0;
		cal_q = 0;
		xsens_q = 256;
		ysens_q = 256;
		dz_q = 0;
		invdz_q = 0;
		tilt_held = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_extremes();
		test_output_hold_off();
		test_random_configs(10, 140);
		idle_on = 1'b0;
		test_random_configs(2, 120);
		drain_outputs();
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("PASS tilt_to_gamepad_mapper_unit");
		else
			$display("FAIL tilt_to_gamepad_mapper_unit");
		$finish;
	end
endmodule

### tilt_to_gamepad_mapper_unit.f
+incdir+hdl
hdl/tgm_pkg.sv
hdl/tgm_sample_if.sv
hdl/tgm_result_if.sv
hdl/tgm_div.sv
hdl/tgm_sqrt.sv
hdl/tilt_to_gamepad_mapper_unit.sv
tb/sv/tb_top.sv
